// ===== design/assert_macros.svh =====
// Assertion macros shared by the sliding window median design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define SWM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence on the next clock edge.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// Shared types and constants of the sliding window median design.
package swm_pkg;

	localparam int CFG_BITS = 7;

	typedef struct packed {
		logic load;
		logic del;
	} swm_ctl_t;

endpackage

// ===== design/sliding_window_median_cost.sv =====
// A result passes through the result flag register, the adder tree and the output queue.
// One sample per cycle when s_tready is high; the sorted cells insert and remove in one update.
// The sum of the window halves goes through a pipelined adder tree of ceil(log2(WINDOW_MAX)) levels.
// Input stalls only when the output queue and the results in flight fill its credits.
// Reset empties the window, sets the window size to one and clears all results in flight.
`include "assert_macros.svh"

module sliding_window_median_cost import swm_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [CFG_BITS-1:0]                         cfg_data,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// Fields from the lowest bit: sample.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
	// Fields from the lowest bit: start_req.
	input  logic                                        s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// Fields from the lowest bit: cost, median.
	output logic [((SAMPLE_BITS+$clog2(WINDOW_MAX)+SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int SB       = SAMPLE_BITS;
	localparam int CB       = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int KW       = $clog2(WINDOW_MAX + 1);
	localparam int IW       = $clog2(WINDOW_MAX);
	localparam int CMPW     = (KW > CFG_BITS) ? KW : CFG_BITS;
	localparam int LEVELS   = $clog2(WINDOW_MAX);
	localparam int TREE_LAT = LEVELS + 1;
	localparam int FD       = LEVELS + 4;
	localparam int FDW      = $clog2(FD + 1);
	localparam int TDW      = ((CB + SB + 7) / 8) * 8;

	logic [KW-1:0]        k_q, half_q, upper_q;
	logic [IW-1:0]        med_idx_q;
	logic [KW-1:0]        fill_q;
	logic [FDW-1:0]       cnt_q;
	logic                 res_q;

	logic [CMPW-1:0]      cfg_ext;
	logic [KW-1:0]        k_new;
	logic                 acc, cfg_acc;
	logic [KW-1:0]        fill_eff, n_after, new_fill;
	logic                 del, res;
	swm_ctl_t             ctl;
	logic signed [SB-1:0] sample;
	logic signed [SB-1:0] old_val;
	logic [IW-1:0]        oldest_age;

	logic signed [SB-1:0] cell_val [WINDOW_MAX];
	logic [IW-1:0]        cell_age [WINDOW_MAX];
	logic signed [SB-1:0] u_val    [WINDOW_MAX];
	logic [IW-1:0]        u_age    [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] cell_ltx, cell_old, lo;
	logic signed [CB-1:0] term     [WINDOW_MAX];

	logic                 tree_vld;
	logic [SB-1:0]        tree_med;
	logic signed [CB-1:0] tree_sum;
	logic                 pop;

	assign cfg_ready  = 1'b1;
	assign cfg_acc    = cfg_valid & cfg_ready;
	assign acc        = s_tvalid & s_tready;
	assign sample     = SB'(s_tdata[SB-1:0]);
	assign cfg_ext    = CMPW'(cfg_data);
	assign oldest_age = IW'(k_q - KW'(1));

	always_comb begin
		priority if (cfg_ext == '0) begin
			k_new = KW'(1);
		end else if (cfg_ext > CMPW'(WINDOW_MAX)) begin
			k_new = KW'(WINDOW_MAX);
		end else begin
			k_new = KW'(cfg_ext);
		end
	end

	assign fill_eff = s_tuser ? '0 : fill_q;
	assign del      = fill_eff == k_q;
	assign n_after  = fill_eff - KW'(del);
	assign new_fill = n_after + KW'(1);
	assign res      = new_fill == k_q;
	assign ctl.load = acc;
	assign ctl.del  = del;

	always_comb begin
		old_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (cell_old[i]) begin
				old_val = old_val | cell_val[i];
			end
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [SB-1:0] up_val;
		logic [IW-1:0]        up_age;
		logic                 up_ltx;
		logic                 ins_ok;
		logic signed [SB-1:0] dn_uval;
		logic [IW-1:0]        dn_uage;

		if (i + 1 < WINDOW_MAX) begin : g_up
			assign up_val = cell_val[i+1];
			assign up_age = cell_age[i+1];
			assign up_ltx = cell_ltx[i+1];
		end else begin : g_top
			assign up_val = '0;
			assign up_age = '0;
			assign up_ltx = 1'b0;
		end

		if (i == 0) begin : g_first
			assign ins_ok  = 1'b1;
			assign dn_uval = '0;
			assign dn_uage = '0;
		end else begin : g_rest
			assign ins_ok  = lo[i-1];
			assign dn_uval = u_val[i-1];
			assign dn_uage = u_age[i-1];
		end

		swm_cell #(
			.SB(SB),
			.IW(IW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sample     (sample),
			.old_val    (old_val),
			.oldest_age (oldest_age),
			.cell_valid (KW'(i) < fill_q),
			.u_valid    (KW'(i) < n_after),
			.up_val     (up_val),
			.up_age     (up_age),
			.up_ltx     (up_ltx),
			.ins_ok     (ins_ok),
			.dn_uval    (dn_uval),
			.dn_uage    (dn_uage),
			.val        (cell_val[i]),
			.age        (cell_age[i]),
			.ltx        (cell_ltx[i]),
			.is_old     (cell_old[i]),
			.lo         (lo[i]),
			.u_val      (u_val[i]),
			.u_age      (u_age[i])
		);

		// The lower half counts negative and the upper half positive; the odd middle drops out.
		always_comb begin
			term[i] = '0;
			if (KW'(i) < half_q) begin
				term[i] = -CB'(cell_val[i]);
			end else if (KW'(i) >= upper_q && KW'(i) < k_q) begin
				term[i] = CB'(cell_val[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= KW'(1);
			half_q    <= '0;
			upper_q   <= KW'(1);
			med_idx_q <= '0;
			fill_q    <= '0;
			res_q     <= 1'b0;
		end else begin
			res_q <= acc & res;
			if (cfg_acc) begin
				k_q       <= k_new;
				half_q    <= k_new >> 1;
				upper_q   <= k_new - (k_new >> 1);
				med_idx_q <= IW'((k_new - KW'(1)) >> 1);
				fill_q    <= '0;
			end else if (acc) begin
				fill_q <= new_fill;
			end
		end
	end

	swm_sum_tree #(
		.N  (WINDOW_MAX),
		.CB (CB),
		.TW (SB)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_q),
		.in_tag    (cell_val[med_idx_q]),
		.terms     (term),
		.out_valid (tree_vld),
		.out_tag   (tree_med),
		.out_sum   (tree_sum)
	);

	assign pop = m_tvalid & m_tready;

	swm_out_fifo #(
		.W     (TDW),
		.DEPTH (FD)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tree_vld),
		.push_data (TDW'({tree_med, tree_sum})),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	// Each accepted transaction that yields a result holds one credit until it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + FDW'(acc & res) - FDW'(pop);
		end
	end

	assign s_tready = cnt_q < FDW'(FD);

	`SWM_ASSERT(a_fill_in_window, fill_q <= k_q, "window fill exceeds window size")
	`SWM_ASSERT(a_one_oldest, $onehot0(cell_old), "more than one cell marked as oldest")
	`SWM_ASSERT(a_credit_bound, cnt_q <= FDW'(FD), "result credits exceed queue depth")
	`SWM_ASSERT(a_tree_latency, res_q |-> ##TREE_LAT tree_vld, "adder tree result missing")
	`SWM_ASSERT_NEXT(a_cfg_empties, cfg_acc, fill_q == '0, "configuration write did not empty window")

endmodule

// ===== design/swm_cell.sv =====
// One slot of the sorted window: holds a sample and its age and shifts with its neighbors.
module swm_cell import swm_pkg::*; #(
	parameter int SB = 32,
	parameter int IW = 6
) (
	input  logic                 clk,
	input  swm_ctl_t             ctl,
	input  logic signed [SB-1:0] sample,
	input  logic signed [SB-1:0] old_val,
	input  logic [IW-1:0]        oldest_age,
	input  logic                 cell_valid,
	input  logic                 u_valid,
	input  logic signed [SB-1:0] up_val,
	input  logic [IW-1:0]        up_age,
	input  logic                 up_ltx,
	input  logic                 ins_ok,
	input  logic signed [SB-1:0] dn_uval,
	input  logic [IW-1:0]        dn_uage,
	output logic signed [SB-1:0] val,
	output logic [IW-1:0]        age,
	output logic                 ltx,
	output logic                 is_old,
	output logic                 lo,
	output logic signed [SB-1:0] u_val,
	output logic [IW-1:0]        u_age
);

	logic signed [SB-1:0] val_q;
	logic [IW-1:0]        age_q;
	logic                 below;
	logic                 u_ltx;

	assign val    = val_q;
	assign age    = age_q;
	assign ltx    = val_q < sample;
	assign is_old = ctl.del & cell_valid & (age_q == oldest_age);

	// A cell stays in place after the removal when it sorts below the removed sample.
	assign below  = !ctl.del | !(is_old | (val_q > old_val));
	assign u_val  = below ? val_q : up_val;
	assign u_age  = below ? age_q : up_age;
	assign u_ltx  = below ? ltx : up_ltx;
	assign lo     = u_valid & u_ltx;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			priority if (lo) begin
				val_q <= u_val;
				age_q <= u_age + IW'(1);
			end else if (ins_ok) begin
				val_q <= sample;
				age_q <= '0;
			end else begin
				val_q <= dn_uval;
				age_q <= dn_uage + IW'(1);
			end
		end
	end

endmodule

// ===== design/swm_sum_tree.sv =====
// Registered adder tree that sums the signed cell contributions and carries a tag alongside.
module swm_sum_tree import swm_pkg::*; #(
	parameter int N  = 64,
	parameter int CB = 38,
	parameter int TW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [TW-1:0]        in_tag,
	input  logic signed [CB-1:0] terms [N],
	output logic                 out_valid,
	output logic [TW-1:0]        out_tag,
	output logic signed [CB-1:0] out_sum
);

	localparam int LEVELS = $clog2(N);
	localparam int N2     = 1 << LEVELS;

	logic signed [CB-1:0] node_q [LEVELS+1][N2];
	logic [TW-1:0]        tag_q  [LEVELS+1];
	logic [LEVELS:0]      vld_q;

	for (genvar j = 0; j < N2; j++) begin : g_leaf
		if (j < N) begin : g_term
			always_ff @(posedge clk) begin
				node_q[0][j] <= terms[j];
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_q[0][j] <= '0;
			end
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar j = 0; j < (N2 >> (l + 1)); j++) begin : g_node
			always_ff @(posedge clk) begin
				node_q[l+1][j] <= node_q[l][2*j] + node_q[l][2*j+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= in_tag;
		for (int l = 1; l <= LEVELS; l++) begin
			tag_q[l] <= tag_q[l-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LEVELS-1:0], in_valid};
		end
	end

	assign out_valid = vld_q[LEVELS];
	assign out_tag   = tag_q[LEVELS];
	assign out_sum   = node_q[LEVELS][0];

endmodule

// ===== design/swm_out_fifo.sv =====
// Small output queue that holds finished results until the downstream side takes them.
module swm_out_fifo import swm_pkg::*; #(
	parameter int W     = 72,
	parameter int DEPTH = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ===== test/tb_sliding_window_median_cost.sv =====
// Self-checking testbench for the sliding window median and absolute deviation cost block.
module tb_sliding_window_median_cost import swm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [37:0] cost;
		logic [31:0] median;
	} median_cost_t;

	class median_window_board;
		int size_reg;
		longint arrivals[SLOTS];
		longint ordered[SLOTS];
		int fill;
		int slot;
		median_cost_t awaited_costs[$];
		int mismatches;

		function new();
			size_reg = 1;
			fill = 0;
			slot = 0;
			mismatches = 0;
		endfunction

		function void set_size(logic [CFG_BITS-1:0] v);
			size_reg = int'(v);
			fill = 0;
			slot = 0;
		endfunction

		function void sort_in(int n, longint v);
			int i;
			i = n;
			while (i > 0 && ordered[i-1] > v) begin
				ordered[i] = ordered[i-1];
				i--;
			end
			ordered[i] = v;
		endfunction

		function void note_sample(logic [31:0] raw, logic restart);
			int k;
			int i;
			int half;
			longint s;
			longint old;
			longint lo;
			longint hi;
			median_cost_t r;
			k = (size_reg < 1) ? 1 : ((size_reg > SLOTS) ? SLOTS : size_reg);
			s = longint'($signed(raw));
			if (restart || fill > k || slot >= k) begin
				fill = 0;
				slot = 0;
			end
			if (fill < k) begin
				arrivals[slot] = s;
				sort_in(fill, s);
				fill++;
			end else begin
				old = arrivals[slot];
				arrivals[slot] = s;
				i = 0;
				while (i < k && ordered[i] != old)
					i++;
				for (; i + 1 < k; i++)
					ordered[i] = ordered[i+1];
				sort_in(k - 1, s);
			end
			slot++;
			if (slot >= k)
				slot = 0;
			if (fill < k)
				return;
			lo = 0;
			hi = 0;
			half = k / 2;
			for (i = 0; i < half; i++) begin
				lo += ordered[i];
				hi += ordered[k-1-i];
			end
			r.cost = 38'(hi - lo);
			r.median = 32'(ordered[(k-1)/2]);
			awaited_costs.push_back(r);
		endfunction

		function void check_result(logic [71:0] data);
			median_cost_t want;
			logic [37:0] got_cost;
			logic [31:0] got_median;
			got_cost = data[37:0];
			got_median = data[69:38];
			if (awaited_costs.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result: cost %0d median %0d", got_cost,
						$signed(got_median));
				mismatches++;
				return;
			end
			want = awaited_costs.pop_front();
			if (got_cost !== want.cost || got_median !== want.median) begin
				if (mismatches < 10)
					$display("Mismatch: cost expected %0d got %0d, median expected %0d got %0d",
						want.cost, got_cost, $signed(want.median), $signed(got_median));
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_BITS-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;

	median_window_board board;
	bit calm;
	int ready_hold;
	int cycles;

	sliding_window_median_cost u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	function automatic logic [31:0] pick_sample(bit extremes_only);
		case ($urandom_range(0, extremes_only ? 1 : 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			3: return 32'h8000_0000 + 32'($urandom_range(0, 3));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_sample(logic [31:0] smp, logic restart);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_sample(smp, restart);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.awaited_costs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.set_size(v);
	endtask

	task automatic run_phase(int count, bit extremes_only, bit pause_midway);
		for (int n = 0; n < count; n++) begin
			if (pause_midway && n == count / 2)
				drain_results();
			send_sample(pick_sample(extremes_only), $urandom_range(0, 59) == 0);
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] sizes[10];
		board = new();
		calm = 1'b0;
		ready_hold = 0;
		cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hffff_ffff, 1'b0);
		send_sample(32'h0000_0001, 1'b1);
		drain_results();
		write_size(7'd3);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h0000_0005, 1'b1);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'hffff_fffb, 1'b0);
		drain_results();
		write_size(7'd0);
		send_sample(32'h1234_5678, 1'b0);
		send_sample(32'hedcb_a987, 1'b1);
		drain_results();

		sizes = '{7'd127, 7'd2, 7'd64, 7'd7, 7'd1, 7'd33, 7'd65, 7'd16, 7'd0, 7'd0};
		sizes[8] = CFG_BITS'($urandom_range(0, 127));
		sizes[9] = CFG_BITS'($urandom_range(0, 127));
		for (int p = 0; p < 10; p++) begin
			write_size(sizes[p]);
			if (p == 9)
				calm = 1'b1;
			run_phase(143, p == 0, p == 2);
			drain_results();
		end

		if (board.mismatches == 0 && board.awaited_costs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
